FILE: rtl/core/arq_sender_window_tracker_top_assert.svh
// ----------------------------------------------------------------------------
// ARQ sender window tracker: assertion macros
// Shared assertion forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ARQ_SENDER_WINDOW_TRACKER_TOP_ASSERT_SVH
`define ARQ_SENDER_WINDOW_TRACKER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/arqswt_pkg.sv
// ----------------------------------------------------------------------------
// ARQ sender window tracker: package
// Operation and result codes, configuration indexes and sequencer states.
// ----------------------------------------------------------------------------
package arqswt_pkg;

  // Operation codes carried by an input word.
  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_e;

  // Result kinds carried by an output word.
  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_NONE = 2'd1,
    KIND_DROP = 2'd2
  } kind_e;

  // Configuration register indexes and widths.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 5;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_SIZE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ACK_MODE    = 1'b1;
  localparam logic [CfgDataW-1:0] WINDOW_SIZE_RESET = 5'd16;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK_SEL,
    ST_MARK_CUM,
    ST_ADVANCE,
    ST_TOUT_COUNT,
    ST_TOUT_SEND,
    ST_EMIT_RUN,
    ST_EMIT_ONE
  } state_e;

endpackage

FILE: rtl/core/arq_sender_window_tracker_top.sv
// ----------------------------------------------------------------------------
// ARQ sender window tracker (go-back-n / selective repeat sender side)
// A start commits its first packets at once, then plays out one result per cycle while the output
// register is free. An ack first marks the acked slot (selective) or each acked packet in turn
// (cumulative), then frees marked slots from the base, then plays out its results.
// A timeout scans the outstanding range twice (count, then send). Throughput: one word at a time,
// set by the single slot walker. Reset at once clears all state but the output data fields.
// ----------------------------------------------------------------------------
`include "arq_sender_window_tracker_top_assert.svh"

module arq_sender_window_tracker_top #(
  parameter int unsigned WINDOW_MAX = 16,
  parameter int unsigned SEQ_BITS   = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [arqswt_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [arqswt_pkg::CfgDataW-1:0]    cfg_data_i,
  // Input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         operation_i,
  input  logic [SEQ_BITS-1:0]                packet_count_i,
  input  logic [SEQ_BITS-1:0]                ack_number_i,
  input  logic                               header_ok_i,
  // Output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         kind_o,
  output logic [SEQ_BITS-1:0]                send_seq_o,
  output logic                               transfer_done_o,
  output logic                               last_o
);

  // Slot indexes address the mark bits; counters must be able to hold a
  // whole window.
  localparam int unsigned SlotW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CntW    = $clog2(WINDOW_MAX + 1);
  localparam int unsigned AwReset = (WINDOW_MAX < 16) ? WINDOW_MAX : 16;

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  arqswt_pkg::state_e state_q, state_d;

  logic [arqswt_pkg::CfgDataW-1:0] window_size_q;
  logic                            ack_mode_q;

  // Window state. The active window is latched at start.
  logic [CntW-1:0]       aw_q;
  logic [WINDOW_MAX-1:0] marks_q;
  logic [SEQ_BITS-1:0]   base_q;
  logic [SlotW-1:0]      base_slot_q;
  logic [SEQ_BITS-1:0]   nseq_q;
  logic [SEQ_BITS-1:0]   mlen_q;
  logic                  done_q;

  // Per-word working registers.
  logic [SEQ_BITS-1:0]   ackn_q;
  logic [SEQ_BITS-1:0]   walk_seq_q;
  logic [SlotW-1:0]      walk_slot_q;
  logic [SEQ_BITS-1:0]   emit_seq_q;
  logic [CntW-1:0]       cnt_q;
  arqswt_pkg::kind_e     one_kind_q;

  // Output register.
  logic                  out_valid_q;
  arqswt_pkg::kind_e     out_kind_q;
  logic [SEQ_BITS-1:0]   out_seq_q;
  logic                  out_done_q;
  logic                  out_last_q;

  logic                  in_accept;
  logic                  out_free;
  logic [CntW-1:0]       clamp_w;
  logic [CntW-1:0]       start_cnt;
  logic                  ack_drop;
  logic [SlotW-1:0]      base_slot_inc;
  logic [SlotW-1:0]      walk_slot_inc;
  logic [SEQ_BITS-1:0]   sel_off;
  logic [CntW:0]         sel_sum;
  logic [SlotW-1:0]      sel_slot;
  logic                  adv_go;
  logic                  tout_pick;

  logic                  emit;
  arqswt_pkg::kind_e     emit_kind;
  logic [SEQ_BITS-1:0]   emit_seq;
  logic                  emit_last;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  // A new word is taken only when the sequencer is idle; the output register
  // lets the last result of a word wait while the next word is accepted.
  assign in_stall_o = (state_q != arqswt_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= arqswt_pkg::WINDOW_SIZE_RESET;
      ack_mode_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        arqswt_pkg::CFG_WINDOW_SIZE: window_size_q <= cfg_data_i;
        arqswt_pkg::CFG_ACK_MODE:    ack_mode_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Shared arithmetic
  // --------------------------------------------------------------------------
  // A window size of zero behaves as one; anything above the slot count is
  // limited to the slot count.
  always_comb begin
    if (window_size_q == '0) begin
      clamp_w = CntW'(1);
    end else if ({3'b000, window_size_q} > 8'(WINDOW_MAX)) begin
      clamp_w = CntW'(WINDOW_MAX);
    end else begin
      clamp_w = CntW'(window_size_q);
    end
  end

  // A start sends the smaller of the message length and the window.
  assign start_cnt = (packet_count_i < SEQ_BITS'(clamp_w)) ? CntW'(packet_count_i) : clamp_w;

  // An ack is dropped on a bad header or when it names no outstanding packet.
  // In selective mode the next unsent number is outside the range as well.
  assign ack_drop = !header_ok_i || (ack_number_i < base_q) || (ack_number_i > nseq_q) ||
                    (ack_mode_q && (ack_number_i == nseq_q));

  // Slot pointers step modulo the active window.
  assign base_slot_inc = ((CntW'(base_slot_q) + CntW'(1)) == aw_q) ? '0
                                                                   : base_slot_q + SlotW'(1);
  assign walk_slot_inc = ((CntW'(walk_slot_q) + CntW'(1)) == aw_q) ? '0
                                                                   : walk_slot_q + SlotW'(1);

  // The acked packet lies less than one window above the base, so its slot
  // is the base slot plus the offset, folded once.
  assign sel_off = ackn_q - base_q;
  assign sel_sum = {1'b0, CntW'(base_slot_q)} + {1'b0, sel_off[CntW-1:0]};
  always_comb begin
    if (sel_sum >= {1'b0, aw_q}) begin
      sel_slot = SlotW'(sel_sum - {1'b0, aw_q});
    end else begin
      sel_slot = SlotW'(sel_sum);
    end
  end

  assign adv_go    = (base_q < nseq_q) && marks_q[base_slot_q];
  assign tout_pick = !ack_mode_q || !marks_q[walk_slot_q];

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      arqswt_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (operation_i)
            arqswt_pkg::OP_START: begin
              state_d = (packet_count_i == '0) ? arqswt_pkg::ST_EMIT_ONE
                                               : arqswt_pkg::ST_EMIT_RUN;
            end
            arqswt_pkg::OP_ACK: begin
              if (ack_drop) begin
                state_d = arqswt_pkg::ST_EMIT_ONE;
              end else if (ack_mode_q) begin
                state_d = arqswt_pkg::ST_MARK_SEL;
              end else begin
                state_d = arqswt_pkg::ST_MARK_CUM;
              end
            end
            arqswt_pkg::OP_TIMEOUT: state_d = arqswt_pkg::ST_TOUT_COUNT;
            default:                state_d = arqswt_pkg::ST_EMIT_ONE;
          endcase
        end
      end
      arqswt_pkg::ST_MARK_SEL: state_d = arqswt_pkg::ST_ADVANCE;
      arqswt_pkg::ST_MARK_CUM: begin
        if (walk_seq_q == ackn_q) begin
          state_d = arqswt_pkg::ST_ADVANCE;
        end
      end
      arqswt_pkg::ST_ADVANCE: begin
        if (!adv_go) begin
          state_d = (cnt_q == '0) ? arqswt_pkg::ST_EMIT_ONE : arqswt_pkg::ST_EMIT_RUN;
        end
      end
      arqswt_pkg::ST_TOUT_COUNT: begin
        if (walk_seq_q == nseq_q) begin
          state_d = (cnt_q == '0) ? arqswt_pkg::ST_EMIT_ONE : arqswt_pkg::ST_TOUT_SEND;
        end
      end
      arqswt_pkg::ST_TOUT_SEND,
      arqswt_pkg::ST_EMIT_RUN,
      arqswt_pkg::ST_EMIT_ONE: begin
        if (emit && emit_last) begin
          state_d = arqswt_pkg::ST_IDLE;
        end
      end
      default: state_d = arqswt_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: result generation
  // --------------------------------------------------------------------------
  always_comb begin
    emit      = 1'b0;
    emit_kind = arqswt_pkg::KIND_SEND;
    emit_seq  = emit_seq_q;
    emit_last = (cnt_q == CntW'(1));
    case (state_q)
      arqswt_pkg::ST_EMIT_RUN: begin
        emit = out_free;
      end
      arqswt_pkg::ST_TOUT_SEND: begin
        emit     = out_free && tout_pick;
        emit_seq = walk_seq_q;
      end
      arqswt_pkg::ST_EMIT_ONE: begin
        emit      = out_free;
        emit_kind = one_kind_q;
        emit_seq  = '0;
        emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arqswt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Window state and working registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q        <= CntW'(AwReset);
      marks_q     <= '0;
      base_q      <= '0;
      base_slot_q <= '0;
      nseq_q      <= '0;
      mlen_q      <= '0;
      done_q      <= 1'b0;
      ackn_q      <= '0;
      walk_seq_q  <= '0;
      walk_slot_q <= '0;
      emit_seq_q  <= '0;
      cnt_q       <= '0;
      one_kind_q  <= arqswt_pkg::KIND_NONE;
    end else begin
      case (state_q)
        arqswt_pkg::ST_IDLE: begin
          if (in_accept) begin
            one_kind_q <= arqswt_pkg::KIND_NONE;
            case (operation_i)
              arqswt_pkg::OP_START: begin
                // The first packets of the message are committed at once;
                // their results are then played out one per cycle while the output register is free.
                aw_q        <= clamp_w;
                marks_q     <= '0;
                base_q      <= '0;
                base_slot_q <= '0;
                nseq_q      <= SEQ_BITS'(start_cnt);
                mlen_q      <= packet_count_i;
                done_q      <= (packet_count_i == '0);
                emit_seq_q  <= '0;
                cnt_q       <= start_cnt;
              end
              arqswt_pkg::OP_ACK: begin
                ackn_q      <= ack_number_i;
                walk_seq_q  <= base_q;
                walk_slot_q <= base_slot_q;
                emit_seq_q  <= nseq_q;
                cnt_q       <= '0;
                if (ack_drop) begin
                  one_kind_q <= arqswt_pkg::KIND_DROP;
                end
              end
              arqswt_pkg::OP_TIMEOUT: begin
                walk_seq_q  <= base_q;
                walk_slot_q <= base_slot_q;
                cnt_q       <= '0;
              end
              default: ;
            endcase
          end
        end
        arqswt_pkg::ST_MARK_SEL: begin
          marks_q[sel_slot] <= 1'b1;
        end
        arqswt_pkg::ST_MARK_CUM: begin
          if (walk_seq_q != ackn_q) begin
            marks_q[walk_slot_q] <= 1'b1;
            walk_seq_q           <= walk_seq_q + SEQ_BITS'(1);
            walk_slot_q          <= walk_slot_inc;
          end
        end
        arqswt_pkg::ST_ADVANCE: begin
          if (adv_go) begin
            // Free the base slot; each freed slot sends the next unsent
            // packet while the message has any left.
            marks_q[base_slot_q] <= 1'b0;
            base_q               <= base_q + SEQ_BITS'(1);
            base_slot_q          <= base_slot_inc;
            if (nseq_q < mlen_q) begin
              nseq_q <= nseq_q + SEQ_BITS'(1);
              cnt_q  <= cnt_q + CntW'(1);
            end
          end else begin
            done_q <= (nseq_q >= mlen_q) && (base_q == nseq_q);
          end
        end
        arqswt_pkg::ST_TOUT_COUNT: begin
          // First pass counts the packets to resend so that the final one
          // can be flagged as it goes out.
          if (walk_seq_q != nseq_q) begin
            if (tout_pick) begin
              cnt_q <= cnt_q + CntW'(1);
            end
            walk_seq_q  <= walk_seq_q + SEQ_BITS'(1);
            walk_slot_q <= walk_slot_inc;
          end else begin
            walk_seq_q  <= base_q;
            walk_slot_q <= base_slot_q;
          end
        end
        arqswt_pkg::ST_TOUT_SEND: begin
          if (!tout_pick || emit) begin
            walk_seq_q  <= walk_seq_q + SEQ_BITS'(1);
            walk_slot_q <= walk_slot_inc;
          end
          if (emit) begin
            cnt_q <= cnt_q - CntW'(1);
          end
        end
        arqswt_pkg::ST_EMIT_RUN: begin
          if (emit) begin
            emit_seq_q <= emit_seq_q + SEQ_BITS'(1);
            cnt_q      <= cnt_q - CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  // The done flag is final by the time any result of a word is produced, so
  // every result of the word carries the same value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q <= emit_kind;
      out_seq_q  <= emit_seq;
      out_done_q <= done_q;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_kind_q;
  assign send_seq_o      = out_seq_q;
  assign transfer_done_o = out_done_q;
  assign last_o          = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASW_ASSERT_NOW(a_base_not_past_next, 1'b1, base_q <= nseq_q,
                  "window base is beyond the next sequence number")
  `ASW_ASSERT_NOW(a_gap_within_window, 1'b1, (nseq_q - base_q) <= SEQ_BITS'(aw_q),
                  "more packets outstanding than the active window")
  `ASW_ASSERT_NOW(a_slot_in_window, 1'b1, CntW'(base_slot_q) < aw_q,
                  "base slot lies outside the active window")
  `ASW_ASSERT_NOW(a_done_settled, done_q, base_q == nseq_q,
                  "done flag set with packets still outstanding")
  `ASW_ASSERT_NOW(a_run_count, (state_q == arqswt_pkg::ST_EMIT_RUN) ||
                  (state_q == arqswt_pkg::ST_TOUT_SEND), cnt_q != '0,
                  "result run entered with no results left")
  `ASW_ASSERT_NEXT(a_word_busy, in_valid_i && !in_stall_o, in_stall_o,
                   "an accepted word did not occupy the sequencer")

endmodule

FILE: dv/arq_sender_window_tracker_top_tb.sv
// ----------------------------------------------------------------------------
// ARQ sender window tracker: self-checking testbench
// Drives start, ack and timeout words into the tracker, predicts the send
// words each one should cause, and checks every result word in order. A short
// table of hand-picked words comes first, then phases of random traffic under
// several window sizes and both ack modes, with random gaps and stalls on both
// channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module arq_sender_window_tracker_top_tb;

  localparam int unsigned WinMax      = 16;
  localparam int unsigned SeqBits     = 16;
  localparam logic [1:0]  OP_RSVD     = 2'd3;
  localparam logic        MODE_CUM    = 1'b0;
  localparam logic        MODE_SEL    = 1'b1;
  // Extra drain after the last owed result, to cover any straggler.
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned PhaseWords  = 24;
  localparam int unsigned RandPhases  = 8;
  // Watchdog limit, set far above the slowest correct run.
  localparam int unsigned CycleLimit  = 300000;

  // One input word as the tracker sees it.
  typedef struct {
    logic [1:0]  op;
    logic [15:0] count;
    logic [15:0] ackn;
    logic        hdr;
  } word_t;

  // One result word.
  typedef struct {
    arqswt_pkg::kind_e kind;
    logic [15:0]       seq;
    logic              done;
    logic              last;
  } result_t;

  // A row of the directed table. Where pin is set, the row causes exactly one
  // result and its kind and done flag are typed in by hand.
  typedef struct {
    bit                cfg_wr;
    logic [4:0]        cfg_win;
    logic              cfg_mode;
    logic [1:0]        op;
    logic [15:0]       count;
    logic [15:0]       ackn;
    logic              hdr;
    bit                pin;
    arqswt_pkg::kind_e pin_kind;
    logic              pin_done;
  } row_t;

  localparam int unsigned DirRows = 25;

  // The table opens on the reset settings (window 16, cumulative acks), so
  // the first rows exercise acks, timeouts and a reserved operation before
  // any message exists.
  row_t dir_rows [DirRows] = '{
    //cfg win    mode      op                       count     ackn      hdr
    //  pin kind                   done
    '{0, 5'd0,  MODE_CUM, arqswt_pkg::OP_ACK,     16'd0,    16'd0,    1'b1,
      1, arqswt_pkg::KIND_NONE, 1'b1},
    '{0, 5'd0,  MODE_CUM, arqswt_pkg::OP_TIMEOUT, 16'hFFFF, 16'hFFFF, 1'b0,
      1, arqswt_pkg::KIND_NONE, 1'b1},
    '{0, 5'd0,  MODE_CUM, OP_RSVD,                16'd0,    16'd0,    1'b0,
      1, arqswt_pkg::KIND_NONE, 1'b1},
    '{0, 5'd0,  MODE_CUM, arqswt_pkg::OP_START,   16'd0,    16'd0,    1'b0,
      1, arqswt_pkg::KIND_NONE, 1'b1},
    '{0, 5'd0,  MODE_CUM, arqswt_pkg::OP_START,   16'hFFFF, 16'd0,    1'b0,
      0, arqswt_pkg::KIND_SEND, 1'b0},
    '{0, 5'd0,  MODE_CUM, arqswt_pkg::OP_ACK,     16'd0,    16'd5,    1'b0,
      1, arqswt_pkg::KIND_DROP, 1'b0},
    '{0, 5'd0,  MODE_CUM, arqswt_pkg::OP_ACK,     16'd0,    16'hFFFF, 1'b1,
      1, arqswt_pkg::KIND_DROP, 1'b0},
    '{0, 5'd0,  MODE_CUM, arqswt_pkg::OP_ACK,     16'd0,    16'd3,    1'b1,
      0, arqswt_pkg::KIND_SEND, 1'b0},
    '{0, 5'd0,  MODE_CUM, arqswt_pkg::OP_ACK,     16'd0,    16'd2,    1'b1,
      1, arqswt_pkg::KIND_DROP, 1'b0},
    '{0, 5'd0,  MODE_CUM, arqswt_pkg::OP_TIMEOUT, 16'd0,    16'd0,    1'b0,
      0, arqswt_pkg::KIND_SEND, 1'b0},
    '{0, 5'd0,  MODE_CUM, arqswt_pkg::OP_ACK,     16'd0,    16'd19,   1'b1,
      0, arqswt_pkg::KIND_SEND, 1'b0},
    '{0, 5'd0,  MODE_CUM, arqswt_pkg::OP_START,   16'd3,    16'd0,    1'b0,
      0, arqswt_pkg::KIND_SEND, 1'b0},
    '{0, 5'd0,  MODE_CUM, arqswt_pkg::OP_ACK,     16'd0,    16'd3,    1'b1,
      0, arqswt_pkg::KIND_SEND, 1'b0},
    '{0, 5'd0,  MODE_CUM, arqswt_pkg::OP_ACK,     16'd0,    16'd3,    1'b1,
      1, arqswt_pkg::KIND_NONE, 1'b1},
    '{1, 5'd4,  MODE_SEL, arqswt_pkg::OP_START,   16'd10,   16'd0,    1'b0,
      0, arqswt_pkg::KIND_SEND, 1'b0},
    '{0, 5'd0,  MODE_SEL, arqswt_pkg::OP_ACK,     16'd0,    16'd2,    1'b1,
      0, arqswt_pkg::KIND_SEND, 1'b0},
    '{0, 5'd0,  MODE_SEL, arqswt_pkg::OP_ACK,     16'd0,    16'd4,    1'b1,
      1, arqswt_pkg::KIND_DROP, 1'b0},
    '{0, 5'd0,  MODE_SEL, arqswt_pkg::OP_TIMEOUT, 16'd0,    16'd0,    1'b0,
      0, arqswt_pkg::KIND_SEND, 1'b0},
    '{0, 5'd0,  MODE_SEL, arqswt_pkg::OP_ACK,     16'd0,    16'd0,    1'b1,
      0, arqswt_pkg::KIND_SEND, 1'b0},
    '{0, 5'd0,  MODE_SEL, arqswt_pkg::OP_ACK,     16'd0,    16'd1,    1'b1,
      0, arqswt_pkg::KIND_SEND, 1'b0},
    '{1, 5'd0,  MODE_CUM, arqswt_pkg::OP_START,   16'd2,    16'd0,    1'b0,
      0, arqswt_pkg::KIND_SEND, 1'b0},
    '{0, 5'd0,  MODE_CUM, arqswt_pkg::OP_ACK,     16'd0,    16'd1,    1'b1,
      0, arqswt_pkg::KIND_SEND, 1'b0},
    '{0, 5'd0,  MODE_CUM, arqswt_pkg::OP_TIMEOUT, 16'd0,    16'd0,    1'b0,
      0, arqswt_pkg::KIND_SEND, 1'b0},
    '{1, 5'd31, MODE_SEL, arqswt_pkg::OP_START,   16'hFFFF, 16'd0,    1'b0,
      0, arqswt_pkg::KIND_SEND, 1'b0},
    '{0, 5'd0,  MODE_SEL, arqswt_pkg::OP_ACK,     16'd0,    16'd0,    1'b1,
      0, arqswt_pkg::KIND_SEND, 1'b0}
  };

  // Block ports.
  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [arqswt_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [arqswt_pkg::CfgDataW-1:0] cfg_data_i;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [1:0]                      operation_i;
  logic [15:0]                     packet_count_i;
  logic [15:0]                     ack_number_i;
  logic                            header_ok_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [1:0]                      kind_o;
  logic [15:0]                     send_seq_o;
  logic                            transfer_done_o;
  logic                            last_o;

  // Our own copy of the tracker: registers as written, plus message state.
  logic [4:0]        tr_cfg_win;
  logic              tr_mode;
  int unsigned       tr_win;
  int unsigned       tr_base;
  int unsigned       tr_next;
  int unsigned       tr_len;
  logic [WinMax-1:0] tr_marks;
  logic              tr_done;

  // Result words still owed by the block, oldest first.
  result_t due_results [$];

  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned cycle_count   = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned useful_words  = 0;
  int unsigned settings_used = 0;
  int unsigned words_by_op [4] = '{0, 0, 0, 0};
  bit          src_idle_on   = 1'b1;
  bit          sink_idle_on  = 1'b1;

  arq_sender_window_tracker_top #(
    .WINDOW_MAX (WinMax),
    .SEQ_BITS   (SeqBits)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .packet_count_i  (packet_count_i),
    .ack_number_i    (ack_number_i),
    .header_ok_i     (header_ok_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .send_seq_o      (send_seq_o),
    .transfer_done_o (transfer_done_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The window register holds 5 bits; zero acts as one and anything above
  // the largest window acts as the largest window.
  function automatic int unsigned clamp_win(input logic [4:0] w);
    if (w == 5'd0) return 1;
    if (w > WinMax) return WinMax;
    return w;
  endfunction

  function automatic void tracker_reset();
    tr_cfg_win = arqswt_pkg::WINDOW_SIZE_RESET;
    tr_mode    = MODE_CUM;
    tr_win     = clamp_win(arqswt_pkg::WINDOW_SIZE_RESET);
    tr_base    = 0;
    tr_next    = 0;
    tr_len     = 0;
    tr_marks   = '0;
    tr_done    = 1'b0;
  endfunction

  function automatic void push_result(ref result_t res[$], input arqswt_pkg::kind_e k,
                                      input int unsigned seq);
    result_t r;
    r.kind = k;
    r.seq  = seq[15:0];
    r.done = 1'b0;
    r.last = 1'b0;
    res.push_back(r);
  endfunction

  // Works out the result words of one accepted word and moves our copy of
  // the window on. The done flag is the value after the word, on every result.
  function automatic void tracker_apply(input word_t w, ref result_t res[$]);
    res.delete();
    case (w.op)
      arqswt_pkg::OP_START: begin
        // The window is latched here; a later register write waits for the
        // next start.
        tr_win   = clamp_win(tr_cfg_win);
        tr_marks = '0;
        tr_base  = 0;
        tr_next  = 0;
        tr_len   = w.count;
        while (tr_next < tr_len && tr_next < tr_win) begin
          push_result(res, arqswt_pkg::KIND_SEND, tr_next);
          tr_next++;
        end
        tr_done = (tr_next >= tr_len) && (tr_base == tr_next);
      end
      arqswt_pkg::OP_ACK: begin
        // In selective mode an ack equal to the next number names no
        // outstanding packet, so it is dropped like one out of range.
        if (!w.hdr || w.ackn < tr_base || w.ackn > tr_next ||
            (tr_mode == MODE_SEL && w.ackn == tr_next)) begin
          push_result(res, arqswt_pkg::KIND_DROP, 0);
        end else begin
          if (tr_mode == MODE_SEL) begin
            tr_marks[w.ackn % tr_win] = 1'b1;
          end else begin
            for (int unsigned s = tr_base; s < w.ackn; s++) tr_marks[s % tr_win] = 1'b1;
          end
          while (tr_base < tr_next && tr_marks[tr_base % tr_win]) begin
            tr_marks[tr_base % tr_win] = 1'b0;
            tr_base++;
            if (tr_next < tr_len) begin
              push_result(res, arqswt_pkg::KIND_SEND, tr_next);
              tr_next++;
            end
          end
          tr_done = (tr_next >= tr_len) && (tr_base == tr_next);
        end
      end
      arqswt_pkg::OP_TIMEOUT: begin
        for (int unsigned s = tr_base; s < tr_next; s++) begin
          if (tr_mode == MODE_CUM || !tr_marks[s % tr_win]) begin
            push_result(res, arqswt_pkg::KIND_SEND, s);
          end
        end
      end
      default: ;
    endcase
    if (res.size() == 0) push_result(res, arqswt_pkg::KIND_NONE, 0);
    foreach (res[i]) begin
      res[i].done = tr_done;
      res[i].last = (i == res.size() - 1);
    end
  endfunction

  // Random traffic is shaped around the live window: mostly acks that land
  // inside it, some timeouts and restarts, and a tail of noise (bad headers,
  // wild ack numbers, the reserved operation). Unused fields carry random
  // bits so that every input bit toggles.
  function automatic word_t random_word();
    word_t       w;
    int unsigned r;
    int unsigned span;
    w.op    = arqswt_pkg::OP_ACK;
    w.count = 16'($urandom);
    w.ackn  = 16'($urandom);
    w.hdr   = 1'($urandom_range(1));
    r       = $urandom_range(99);
    span    = tr_next - tr_base;
    if (r < 4 || (tr_done && r < 60)) begin
      w.op = arqswt_pkg::OP_START;
      // Mostly short messages; now and then a huge one that a later start
      // abandons part way.
      if ($urandom_range(9) != 0) begin
        w.count = 16'($urandom_range(3 * clamp_win(tr_cfg_win) + 2));
      end
    end else if (r < 14) begin
      w.op = arqswt_pkg::OP_TIMEOUT;
    end else if (r < 16) begin
      w.op = OP_RSVD;
    end else if (r >= 26) begin
      w.hdr = ($urandom_range(19) != 0);
      if (tr_mode == MODE_SEL && span != 0) w.ackn = 16'(tr_base + $urandom_range(span - 1));
      else w.ackn = 16'(tr_base + $urandom_range(span));
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Offers one word, after a random gap if idling is on, and holds it until
  // the block takes it. Entered and left just after a falling edge, so valid
  // is assigned at most once in any time step.
  task automatic put_word(input word_t w, input bit pin, input arqswt_pkg::kind_e pin_kind,
                          input logic pin_done);
    result_t res [$];
    result_t one;
    while (src_idle_on && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= w.op;
    packet_count_i <= w.count;
    ack_number_i   <= w.ackn;
    header_ok_i    <= w.hdr;
    do @(posedge clk_i); while (in_stall_o);
    tracker_apply(w, res);
    if (pin) begin
      one.kind = pin_kind;
      one.seq  = '0;
      one.done = pin_done;
      one.last = 1'b1;
      res      = '{one};
    end
    foreach (res[i]) due_results.push_back(res[i]);
    words_by_op[w.op]++;
    if (w.op != OP_RSVD && res[0].kind != arqswt_pkg::KIND_DROP) useful_words++;
    @(negedge clk_i);
  endtask

  // Waits for every owed result, lets the block settle, then writes both
  // registers on consecutive cycles.
  task automatic settle_and_configure(input logic [4:0] win, input logic mode);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= arqswt_pkg::CFG_WINDOW_SIZE;
    cfg_data_i  <= win;
    @(negedge clk_i);
    cfg_index_i <= arqswt_pkg::CFG_ACK_MODE;
    cfg_data_i  <= {{(arqswt_pkg::CfgDataW-1){1'b0}}, mode};
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    tr_cfg_win    = win;
    tr_mode       = mode;
    settings_used++;
  endtask

  // Receiver: random stalls, and on request one long hold-off, counted here,
  // during which the sender keeps offering words until the block backs up.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served++;
        out_stall_i <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= sink_idle_on && ($urandom_range(99) < 9);
      end
    end
  end

  // Every result word taken by the receiver is matched against the oldest
  // owed one. Outputs are read at the rising edge, before the block updates.
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result with none owed: kind %0d seq %0d done %b last %b",
                                  kind_o, send_seq_o, transfer_done_o, last_o));
      end else begin
        e = due_results.pop_front();
        if (kind_o !== e.kind || send_seq_o !== e.seq || transfer_done_o !== e.done ||
            last_o !== e.last) begin
          report_mismatch($sformatf({"got kind %0d seq %0d done %b last %b, ",
                                     "wanted kind %0d seq %0d done %b last %b"},
                                    kind_o, send_seq_o, transfer_done_o, last_o,
                                    e.kind, e.seq, e.done, e.last));
        end
      end
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Run stopped at the cycle limit with %0d results still owed",
             due_results.size());
    $display("FAILURE");
    $finish;
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin
    word_t      w;
    logic [4:0] ph_win;
    logic       ph_mode;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    operation_i    = arqswt_pkg::OP_START;
    packet_count_i = '0;
    ack_number_i   = '0;
    header_ok_i    = 1'b0;
    tracker_reset();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: rows that change a register first drain the block.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_wr) settle_and_configure(dir_rows[i].cfg_win, dir_rows[i].cfg_mode);
      w.op    = dir_rows[i].op;
      w.count = dir_rows[i].count;
      w.ackn  = dir_rows[i].ackn;
      w.hdr   = dir_rows[i].hdr;
      put_word(w, dir_rows[i].pin, dir_rows[i].pin_kind, dir_rows[i].pin_done);
    end

    // Random phases. Message state carries across phases, so a mode change
    // lands in the middle of a message. Phase 3 runs with no idling at all,
    // phase 4 carries the long receiver hold-off.
    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0:       begin ph_win = 5'd1;  ph_mode = MODE_CUM; end
        1:       begin ph_win = 5'd16; ph_mode = MODE_SEL; end
        2:       begin ph_win = 5'd0;  ph_mode = MODE_SEL; end
        3:       begin ph_win = 5'd31; ph_mode = MODE_CUM; end
        4:       begin ph_win = 5'd16; ph_mode = MODE_CUM; end
        default: begin
          ph_win  = 5'($urandom_range(2, 15));
          ph_mode = 1'($urandom_range(1));
        end
      endcase
      settle_and_configure(ph_win, ph_mode);
      src_idle_on  = (p != 3);
      sink_idle_on = (p != 3);
      if (p == 4) hold_requests++;
      useful_words = 0;
      while (useful_words < PhaseWords) begin
        put_word(random_word(), 1'b0, arqswt_pkg::KIND_SEND, 1'b0);
      end
    end

    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Sent %0d start, %0d ack, %0d timeout and %0d reserved words under %0d settings;",
             words_by_op[arqswt_pkg::OP_START], words_by_op[arqswt_pkg::OP_ACK],
             words_by_op[arqswt_pkg::OP_TIMEOUT], words_by_op[OP_RSVD], settings_used);
    $display("compared %0d result words, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
